[sv/shtlp_pkg.sv]
package shtlp_pkg;

   typedef enum logic [2:0] {
      ST_FOUND     = 3'd0,
      ST_INSERTED  = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_TOO_LONG  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_READ,
      FSM_CHECK,
      FSM_WRITE,
      FSM_CLEAR
   } fsm_type;

   localparam logic [31:0] HASH_MULT = 32'd31;

endpackage

[sv/shtlp_ram.sv]
module shtlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[sv/string_hash_table_linear_probe_unit.sv]
// String hash table with linear probing.
// A key arrives one byte per transaction on req_key_byte, with req_last
// marking the final byte; req_mode on that final byte selects search (0)
// or insert (1). A transaction is taken when start is high and busy is low.
// Non-final bytes cause no result and leave busy low.
// On a final byte the block folds the hash, then walks the table from the
// home slot: each probed slot takes a slot read state, then a check state
// (compare of the stored key in one wide word and decision); from 1 to
// TABLE_SIZE slots are probed. An insert adds a write state.
// The result is shown on the rsp_ ports for one cycle with rsp_valid high;
// the receiver cannot stall. busy is high from the final byte until the
// result cycle, in which it is low again.
// After reset the block clears every slot word of the table memory, one
// slot a cycle, with busy high. Keys longer than KEY_BYTES report key too
// long without probing or raising busy, in the cycle after the final byte.
module string_hash_table_linear_probe_unit #(
   parameter int TABLE_SIZE = 1024,
   parameter int KEY_BYTES  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_mode,
   input  logic [7:0]                    req_key_byte,
   input  logic                          req_last,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [$clog2(TABLE_SIZE)-1:0] rsp_slot,
   output logic [$clog2(TABLE_SIZE)-1:0] rsp_home_slot,
   output logic [$clog2(TABLE_SIZE+1)-1:0] rsp_entry_count
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam int CW = $clog2(TABLE_SIZE+1);
   localparam int LW = $clog2(KEY_BYTES+2);
   localparam int KW = 8*KEY_BYTES;
   // Slot word: valid bit, key length, key bytes.
   localparam int SW = 1 + LW + KW;
   localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SIZE-1);

   shtlp_pkg::fsm_type state_ff, state_in;
   logic [31:0]   hash_ff, hash_in;
   logic [KW-1:0] key_ff, key_in;
   logic [LW-1:0] len_ff, len_in;
   logic          mode_ff, mode_in;
   logic [AW-1:0] home_ff, home_in, idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in, probes_ff, probes_in;
   logic          rv_ff, rv_in;
   logic [2:0]    rst_ff, rst_in;
   logic [AW-1:0] rslot_ff, rslot_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [SW-1:0] wr_data, rd_data;
   logic          accept;
   logic [31:0]   hash_next;
   logic          match;

   shtlp_ram #(.WIDTH(SW), .DEPTH(TABLE_SIZE)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign accept    = start && !busy;
   assign hash_next = 32'(req_key_byte) + shtlp_pkg::HASH_MULT * hash_ff;
   assign match     = (rd_data[SW-2 -: LW] == len_ff) && (rd_data[KW-1:0] == key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= shtlp_pkg::FSM_CLEAR;
         hash_ff  <= '0;
         key_ff   <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         key_ff   <= key_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         rv_ff    <= rv_in;
      end
      mode_ff   <= mode_in;
      home_ff   <= home_in;
      probes_ff <= probes_in;
      rst_ff    <= rst_in;
      rslot_ff  <= rslot_in;
   end

   always_comb begin
      state_in  = state_ff;
      hash_in   = hash_ff;
      key_in    = key_ff;
      len_in    = len_ff;
      mode_in   = mode_ff;
      home_in   = home_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      probes_in = probes_ff;
      rv_in     = 1'b0;
      rst_in    = rst_ff;
      rslot_in  = rslot_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = {1'b1, len_ff, key_ff};
      busy      = 1'b1;
      unique case (state_ff)
         shtlp_pkg::FSM_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == LAST_SLOT) begin
               idx_in   = '0;
               state_in = shtlp_pkg::FSM_IDLE;
            end
         end
         shtlp_pkg::FSM_IDLE: begin
            busy = 1'b0;
            if (accept) begin
               hash_in = hash_next;
               if (len_ff < LW'(KEY_BYTES)) begin
                  key_in[len_ff[LW-1:0]*8 +: 8] = req_key_byte;
               end
               if (len_ff <= LW'(KEY_BYTES)) begin
                  len_in = len_ff + 1'b1;
               end
               if (req_last) begin
                  mode_in   = req_mode;
                  // The home slot is the hash modulo TABLE_SIZE.
                  home_in   = AW'(hash_next % TABLE_SIZE);
                  idx_in    = AW'(hash_next % TABLE_SIZE);
                  probes_in = '0;
                  rslot_in  = '0;
                  if (len_ff >= LW'(KEY_BYTES)) begin
                     rst_in = shtlp_pkg::ST_TOO_LONG;
                     rv_in  = 1'b1;
                     hash_in = '0;
                     len_in  = '0;
                     key_in  = '0;
                  end else begin
                     state_in = shtlp_pkg::FSM_READ;
                  end
               end
            end
         end
         shtlp_pkg::FSM_READ: begin
            state_in = shtlp_pkg::FSM_CHECK;
         end
         shtlp_pkg::FSM_CHECK: begin
            state_in = shtlp_pkg::FSM_IDLE;
            if (!rd_data[SW-1]) begin
               if (mode_ff) begin
                  state_in = shtlp_pkg::FSM_WRITE;
               end else begin
                  rst_in = shtlp_pkg::ST_NOT_FOUND;
               end
            end else if (match) begin
               rst_in   = shtlp_pkg::ST_FOUND;
               rslot_in = idx_ff;
            end else if (probes_ff == CW'(TABLE_SIZE-1)) begin
               rst_in = mode_ff ? shtlp_pkg::ST_FULL : shtlp_pkg::ST_NOT_FOUND;
            end else begin
               probes_in = probes_ff + 1'b1;
               idx_in    = (idx_ff == LAST_SLOT) ? '0 : idx_ff + 1'b1;
               state_in  = shtlp_pkg::FSM_READ;
            end
            if (state_in == shtlp_pkg::FSM_IDLE) begin
               rv_in   = 1'b1;
               hash_in = '0;
               len_in  = '0;
               key_in  = '0;
            end
         end
         shtlp_pkg::FSM_WRITE: begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
            rst_in   = shtlp_pkg::ST_INSERTED;
            rslot_in = idx_ff;
            rv_in    = 1'b1;
            hash_in  = '0;
            len_in   = '0;
            key_in   = '0;
            state_in = shtlp_pkg::FSM_IDLE;
         end
         default: state_in = shtlp_pkg::FSM_IDLE;
      endcase
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = rst_ff;
   assign rsp_slot        = rslot_ff;
   assign rsp_home_slot   = home_ff;
   assign rsp_entry_count = count_ff;

endmodule

[sv/shtlp_checker.sv]
module shtlp_checker #(
   parameter int TABLE_SIZE = 1024
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          req_last,
   input logic                          rsp_valid,
   input logic [2:0]                    rsp_status,
   input logic [$clog2(TABLE_SIZE+1)-1:0] rsp_entry_count
);

   // A result never arrives back to back with another.
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in a row");

   // A non-final byte causes no result.
   a_nolast: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last) |=> !rsp_valid)
      else $error("result after non-final byte");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= shtlp_pkg::ST_TOO_LONG))
      else $error("bad status");

   // Only an insert raises the count.
   a_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(!reset) && rsp_entry_count != $past(rsp_entry_count))
      |-> (rsp_status == shtlp_pkg::ST_INSERTED))
      else $error("count moved without insert");

endmodule

bind string_hash_table_linear_probe_unit shtlp_checker #(.TABLE_SIZE(TABLE_SIZE)) u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .req_last(req_last),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_entry_count(rsp_entry_count)
);
